// ----- hw/rtl/rmpc_pkg.sv -----
// ----------------------------------------------------------------------------
// rmpc_pkg
// Shared types and constants of the RSSI median proximity classifier.
// ----------------------------------------------------------------------------
package rmpc_pkg;

  typedef logic signed [7:0] sample_t;

  localparam int COUNT_W = 3;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    CLASS_NEAR    = 2'd0,
    CLASS_MID     = 2'd1,
    CLASS_FAR     = 2'd2,
    CLASS_UNKNOWN = 2'd3
  } proximity_t;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  localparam int REG_ADDR_W = 2;
  localparam logic [REG_ADDR_W-1:0] REG_NEAR = 2'd0;
  localparam logic [REG_ADDR_W-1:0] REG_MID  = 2'd1;
  localparam logic [REG_ADDR_W-1:0] REG_FAR  = 2'd2;

  localparam sample_t RING_INIT  = -8'sd85;
  localparam sample_t NEAR_RESET = -8'sd60;
  localparam sample_t MID_RESET  = -8'sd75;
  localparam sample_t FAR_RESET  = -8'sd90;

endpackage

// ----- hw/rtl/rmpc_median.sv -----
// ----------------------------------------------------------------------------
// rmpc_median
// Picks the element of rank count/2 among the first count window entries,
// using a parallel rank network; returns the empty value when count is zero.
// ----------------------------------------------------------------------------
module rmpc_median import rmpc_pkg::*; #(
  parameter int WINDOW = 5
) (
  input  sample_t window [WINDOW],
  input  count_t  count,
  input  sample_t empty_value,
  output sample_t median
);

  count_t rank [WINDOW];
  count_t target;

  assign target = count >> 1;

  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if (j != i && COUNT_W'(j) < count) begin
          if (window[j] < window[i] || (window[j] == window[i] && j < i)) begin
            rank[i] = rank[i] + COUNT_W'(1);
          end
        end
      end
    end
  end

  always_comb begin
    median = empty_value;
    for (int i = 0; i < WINDOW; i++) begin
      if (COUNT_W'(i) < count && rank[i] == target) begin
        median = window[i];
      end
    end
  end

endmodule

// ----- hw/rtl/rssi_median_proximity_classifier.sv -----
// ----------------------------------------------------------------------------
// rssi_median_proximity_classifier
// Median filter over the last WINDOW RSSI samples with a proximity class.
// ----------------------------------------------------------------------------
// Each transaction on the input stream pushes one sample or clears the window,
// and yields exactly one result: the median of the held samples, its class
// against the near, mid and far thresholds, and the number of samples held.
// One transaction is accepted each clock cycle unless a result is stalled;
// it passes an input register, then a result register, with the window
// update and rank network between. The user must write thresholds via the
// configuration port only while the stream is idle; the block does not enforce it.
module rssi_median_proximity_classifier import rmpc_pkg::*; #(
  parameter int WINDOW = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] sample
  input  logic                  s_tuser,   // [0] op
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,   // [7:0] filtered_rssi, [9:8] proximity,
                                           // [12:10] filled, [15:13] zero
  input  logic                  cfg_we,
  input  logic [REG_ADDR_W-1:0] cfg_addr,
  input  logic [7:0]            cfg_wdata
);

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  sample_t near_threshold;
  sample_t mid_threshold;
  sample_t far_threshold;

  logic    in_valid;
  op_t     in_op;
  sample_t in_sample;

  sample_t              ring [WINDOW];
  sample_t              ring_next [WINDOW];
  logic [IDX_W-1:0]     write_slot;
  logic [IDX_W-1:0]     write_slot_next;
  count_t               fill_count;
  count_t               fill_count_next;

  sample_t    median;
  proximity_t proximity;
  logic       advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_threshold <= NEAR_RESET;
      mid_threshold  <= MID_RESET;
      far_threshold  <= FAR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_NEAR: near_threshold <= cfg_wdata;
        REG_MID:  mid_threshold  <= cfg_wdata;
        REG_FAR:  far_threshold  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op     <= op_t'(s_tuser);
      in_sample <= s_tdata;
    end
  end

  always_comb begin
    ring_next       = ring;
    write_slot_next = write_slot;
    fill_count_next = fill_count;
    unique case (in_op)
      OP_PUSH: begin
        ring_next[write_slot] = in_sample;
        if (write_slot == IDX_W'(WINDOW - 1)) begin
          write_slot_next = '0;
        end else begin
          write_slot_next = write_slot + IDX_W'(1);
        end
        if (fill_count < COUNT_W'(WINDOW)) begin
          fill_count_next = fill_count + COUNT_W'(1);
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < WINDOW; i++) begin
          ring_next[i] = far_threshold;
        end
        write_slot_next = '0;
        fill_count_next = '0;
      end
      default: ;
    endcase
  end

  rmpc_median #(
    .WINDOW(WINDOW)
  ) u_median (
    .window     (ring_next),
    .count      (fill_count_next),
    .empty_value(far_threshold),
    .median     (median)
  );

  always_comb begin
    priority if (median >= near_threshold) begin
      proximity = CLASS_NEAR;
    end else if (median >= mid_threshold) begin
      proximity = CLASS_MID;
    end else if (median >= far_threshold) begin
      proximity = CLASS_FAR;
    end else begin
      proximity = CLASS_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring[i] <= RING_INIT;
      end
      write_slot <= '0;
      fill_count <= '0;
      m_tvalid   <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
      if (in_valid) begin
        ring       <= ring_next;
        write_slot <= write_slot_next;
        fill_count <= fill_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      m_tdata <= {3'b000, fill_count_next, proximity, median};
    end
  end

endmodule

// ----- hw/rtl/rmpc_checker.sv -----
// ----------------------------------------------------------------------------
// rmpc_checker
// Port-level checks of the RSSI median proximity classifier, bound to the top.
// ----------------------------------------------------------------------------
module rmpc_checker import rmpc_pkg::*; #(
  parameter int WINDOW = 5
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  a_reset_empties: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Result valid directly after reset.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled result transaction changed.");

  a_filled_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[12:10] <= COUNT_W'(WINDOW))
    else $error("Filled count exceeds the window size.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("Input stalled although no result is waiting.");

endmodule

bind rssi_median_proximity_classifier rmpc_checker #(
  .WINDOW(WINDOW)
) u_rmpc_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSSI median proximity classifier testbench
// Streams pushes and clears through the block under several threshold
// settings, predicts the median, the class and the fill level of every
// result, and compares each returned transaction field by field.
// ----------------------------------------------------------------------------
module tb;
  import rmpc_pkg::*;

  localparam int WIN = 5;
  localparam int STALL_LIMIT = 2000;
  localparam int IDLE_PCT = 22;
  localparam int PHASE_ITEMS = 255;
  localparam logic [REG_ADDR_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    op_t     op;
    sample_t sample;
  } rssi_item_t;

  typedef struct packed {
    sample_t    rssi;
    proximity_t prox;
    count_t     filled;
  } reading_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [15:0]           m_tdata;
  logic                  cfg_we = 1'b0;
  logic [REG_ADDR_W-1:0] cfg_addr = '0;
  logic [7:0]            cfg_wdata = '0;

  rssi_item_t sample_queue[$];
  reading_t   expected_readings[$];

  sample_t win_samples[WIN];
  count_t  win_slot;
  count_t  win_fill;
  sample_t near_thr = NEAR_RESET;
  sample_t mid_thr  = MID_RESET;
  sample_t far_thr  = FAR_RESET;

  bit calm = 1'b0;
  int errors = 0;
  int stall_cycles = 0;

  rssi_median_proximity_classifier dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("MISMATCH %s: got %0d, expected %0d at %0t",
             what, got, want, $realtime);
  endtask

  function automatic proximity_t classify_rssi(input sample_t v);
    if (v >= near_thr) return CLASS_NEAR;
    if (v >= mid_thr) return CLASS_MID;
    if (v >= far_thr) return CLASS_FAR;
    return CLASS_UNKNOWN;
  endfunction

  function automatic sample_t median_of_held();
    sample_t sorted[WIN];
    sample_t key;
    int j;
    if (win_fill == 0) return far_thr;
    for (int i = 0; i < WIN; i++) sorted[i] = win_samples[i];
    for (int i = 1; i < int'(win_fill); i++) begin
      key = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    return sorted[win_fill / 2];
  endfunction

  task automatic advance_window(input rssi_item_t item);
    reading_t r;
    if (item.op == OP_PUSH) begin
      win_samples[win_slot] = item.sample;
      win_slot = (win_slot == WIN - 1) ? count_t'(0) : win_slot + 1'b1;
      if (win_fill < WIN) win_fill = win_fill + 1'b1;
    end else begin
      for (int i = 0; i < WIN; i++) win_samples[i] = far_thr;
      win_slot = '0;
      win_fill = '0;
    end
    r.rssi = median_of_held();
    r.prox = classify_rssi(r.rssi);
    r.filled = win_fill;
    expected_readings.push_back(r);
  endtask

  task automatic check_reading();
    reading_t want;
    sample_t got_rssi;
    proximity_t got_prox;
    count_t got_filled;
    got_rssi = sample_t'(m_tdata[7:0]);
    got_prox = proximity_t'(m_tdata[9:8]);
    got_filled = count_t'(m_tdata[12:10]);
    if (expected_readings.size() == 0) begin
      report_mismatch("result with nothing expected, filtered_rssi", int'(got_rssi), 0);
    end else begin
      want = expected_readings.pop_front();
      if (got_rssi != want.rssi)
        report_mismatch("filtered_rssi", int'(got_rssi), int'(want.rssi));
      if (got_prox != want.prox)
        report_mismatch("proximity", int'(got_prox), int'(want.prox));
      if (got_filled != want.filled)
        report_mismatch("filled", int'(got_filled), int'(want.filled));
    end
  endtask

  always @(posedge clk) begin : drive_samples
    rssi_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        nxt.op = op_t'(s_tuser);
        nxt.sample = sample_t'(s_tdata);
        advance_window(nxt);
      end
      if (!s_tvalid || s_tready) begin
        if (sample_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = sample_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= nxt.sample;
          s_tuser <= nxt.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_reading();
      m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic enqueue(input op_t op, input sample_t sample);
    rssi_item_t item;
    item.op = op;
    item.sample = sample;
    sample_queue.push_back(item);
  endtask

  task automatic drain_stream();
    @(negedge clk);
    while (sample_queue.size() != 0 || s_tvalid || expected_readings.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic program_thresholds(input sample_t n, input sample_t m, input sample_t f);
    logic [REG_ADDR_W-1:0] addrs[4];
    sample_t vals[4];
    addrs = '{REG_NEAR, REG_MID, REG_FAR, REG_SPARE};
    vals = '{n, m, f, sample_t'($urandom_range(255))};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_addr <= addrs[i];
      cfg_wdata <= vals[i];
      case (addrs[i])
        REG_NEAR: near_thr = vals[i];
        REG_MID:  mid_thr = vals[i];
        REG_FAR:  far_thr = vals[i];
        default: ;
      endcase
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic sample_t pick_sample();
    sample_t thr;
    case ($urandom_range(9))
      0: return $urandom_range(1) ? sample_t'(8'h7F) : sample_t'(8'h80);
      1, 2, 3: begin
        case ($urandom_range(2))
          0: thr = near_thr;
          1: thr = mid_thr;
          default: thr = far_thr;
        endcase
        return thr + sample_t'($urandom_range(4)) - sample_t'(8'sd2);
      end
      default: return sample_t'($urandom_range(255));
    endcase
  endfunction

  task automatic run_random_phase(input int count);
    @(negedge clk);
    for (int i = 0; i < count; i++)
      enqueue(($urandom_range(99) < 6) ? OP_CLEAR : OP_PUSH, pick_sample());
    drain_stream();
  endtask

  initial begin
    for (int i = 0; i < WIN; i++) win_samples[i] = RING_INIT;
    win_slot = '0;
    win_fill = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    enqueue(OP_PUSH, 8'sd127);
    enqueue(OP_PUSH, sample_t'(8'h80));
    enqueue(OP_PUSH, 8'sd0);
    enqueue(OP_PUSH, -8'sd1);
    enqueue(OP_PUSH, sample_t'(8'h80));
    enqueue(OP_PUSH, 8'sd127);
    enqueue(OP_PUSH, -8'sd61);
    enqueue(OP_CLEAR, 8'sd0);
    enqueue(OP_PUSH, -8'sd60);
    enqueue(OP_CLEAR, 8'sd0);
    enqueue(OP_PUSH, -8'sd61);
    enqueue(OP_CLEAR, 8'sd0);
    enqueue(OP_PUSH, -8'sd75);
    enqueue(OP_CLEAR, 8'sd0);
    enqueue(OP_PUSH, -8'sd76);
    enqueue(OP_CLEAR, 8'sd0);
    enqueue(OP_PUSH, -8'sd90);
    enqueue(OP_CLEAR, 8'sd0);
    enqueue(OP_PUSH, -8'sd91);
    enqueue(OP_CLEAR, sample_t'(8'h5A));
    enqueue(OP_CLEAR, sample_t'(8'hA5));
    enqueue(OP_PUSH, 8'sd85);
    drain_stream();

    run_random_phase(PHASE_ITEMS);

    program_thresholds(8'sd127, 8'sd127, 8'sd127);
    run_random_phase(PHASE_ITEMS);

    calm = 1'b1;
    program_thresholds(sample_t'(8'h80), sample_t'(8'h80), sample_t'(8'h80));
    run_random_phase(PHASE_ITEMS);
    calm = 1'b0;

    program_thresholds(-8'sd100, 8'sd0, 8'sd50);
    run_random_phase(PHASE_ITEMS);

    program_thresholds(sample_t'($urandom_range(255)), sample_t'($urandom_range(255)),
                       sample_t'($urandom_range(255)));
    run_random_phase(PHASE_ITEMS);

    program_thresholds(8'sd127, 8'sd0, sample_t'(8'h80));
    run_random_phase(PHASE_ITEMS);

    repeat (4) @(posedge clk);
    if (errors == 0 && expected_readings.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/rmpc_pkg.sv
hw/rtl/rmpc_median.sv
hw/rtl/rssi_median_proximity_classifier.sv
hw/rtl/rmpc_checker.sv
test/tb.sv
